// ===== design/kcs_pkg.sv =====
// Shared types, constants and helpers of the k-mer contig segmenter.
package kcs_pkg;

  localparam int unsigned POS_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam logic [POS_W-1:0] MAX_READ_LEN = 16'hFFFF;

  localparam logic [7:0] KMER_SIZE_RST  = 8'd31;
  localparam logic [7:0] QUAL_CUT_RST   = 8'd0;
  localparam logic [7:0] HOMO_CUT_RST   = 8'd0;
  localparam logic [7:0] RUN_MAX        = 8'd255;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KMER_SIZE = 2'd0,
    CFG_QUAL_CUT  = 2'd1,
    CFG_HOMO_CUT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] base;
    logic [7:0] quality;
    logic       quality_present;
    logic       last_base;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] contig_begin;
    logic [POS_W-1:0] contig_stop;
    logic             last_of_run;
  } out_item_t;

  // Up to two results written into the output queue in one cycle.
  typedef struct packed {
    logic      push0;
    logic      push1;
    out_item_t item0;
    out_item_t item1;
  } out_push_t;

  function automatic logic is_acgt(input logic [7:0] c);
    logic r;
    case (c)
      8'h41, 8'h43, 8'h47, 8'h54,
      8'h61, 8'h63, 8'h67, 8'h74: r = 1'b1;
      default:                    r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/kcs_out_fifo.sv =====
// Four-entry result queue that takes up to two items per cycle.
module kcs_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kcs_pkg::out_push_t  push_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kcs_pkg::out_item_t  out_item_o
);

  kcs_pkg::out_item_t mem_q [kcs_pkg::FIFO_DEPTH];

  logic [kcs_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [kcs_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [kcs_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic [kcs_pkg::FIFO_CNT_W-1:0] n_push;
  logic                           pop;

  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign room2_o     = (count_q <= kcs_pkg::FIFO_CNT_W'(kcs_pkg::FIFO_DEPTH - 2));
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    n_push   = kcs_pkg::FIFO_CNT_W'(push_i.push0) + kcs_pkg::FIFO_CNT_W'(push_i.push1);
    wr_ptr_d = wr_ptr_q + n_push[kcs_pkg::FIFO_PTR_W-1:0];
    rd_ptr_d = rd_ptr_q + kcs_pkg::FIFO_PTR_W'(pop);
    count_d  = count_q + n_push - kcs_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.item0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_q + kcs_pkg::FIFO_PTR_W'(1)] <= push_i.item1;
    end
  end

endmodule

// ===== design/kmer_contig_segmenter.sv =====
// Top level of the k-mer contig segmenter: input stage, contig tracker, result queue.
//
//  channel | direction | handshake                 | payload
//  in      | in        | in_valid_i / in_stall_o   | in_item_i  (base, quality, flags)
//  out     | out       | out_valid_o / out_stall_i | out_item_o (contig bounds, last flag)
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One base per cycle unless the input stalls: an item is captured in the input register,
// and its contig update and up to two results are computed from that register.
// The input register advances while the four-entry result queue has room for two.
// A base that closes two contigs queues both results at once; the queue absorbs the extra one.
// Reset clears all position and run state and loads the register defaults.
module kmer_contig_segmenter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  kcs_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output kcs_pkg::out_item_t                out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kcs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [7:0]                        cfg_data_i
);

  localparam int unsigned PW = kcs_pkg::POS_W;

  logic [7:0] kmer_size_q, qual_cut_q, homo_cut_q;

  logic              in_valid_q;
  kcs_pkg::in_item_t in_q;
  logic              room2;
  logic              proc;

  logic [PW-1:0] base_index_q, base_index_d;
  logic [PW-1:0] seg_start_q, seg_start_d;
  logic          seg_open_q, seg_open_d;
  logic [7:0]    run_len_q, run_len_d;
  logic [7:0]    prev_base_q, prev_base_d;

  logic          good;
  logic [7:0]    k_eff, h_eff, run_new;
  logic [PW-1:0] p, len_p, e_last, start_mid;
  logic [PW:0]   p_plus1, p_plus2, ns_wide;
  logic [PW-1:0] ns;
  logic          open_mid;
  logic          emit0, emit_last;
  kcs_pkg::out_item_t res_first, res_last;
  kcs_pkg::out_push_t push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_size_q <= kcs_pkg::KMER_SIZE_RST;
      qual_cut_q  <= kcs_pkg::QUAL_CUT_RST;
      homo_cut_q  <= kcs_pkg::HOMO_CUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (kcs_pkg::cfg_reg_e'(cfg_index_i))
        kcs_pkg::CFG_KMER_SIZE: kmer_size_q <= cfg_data_i;
        kcs_pkg::CFG_QUAL_CUT:  qual_cut_q  <= cfg_data_i;
        kcs_pkg::CFG_HOMO_CUT:  homo_cut_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage: hold the item until the queue can take both possible results.
  assign proc       = in_valid_q && room2;
  assign in_stall_o = in_valid_q && !room2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // Contig tracking for the item in the input register.
  always_comb begin
    k_eff = (kmer_size_q == 8'd0) ? 8'd1 : kmer_size_q;
    h_eff = (homo_cut_q == 8'd1) ? 8'd2 : homo_cut_q;
    p     = base_index_q;
    good  = kcs_pkg::is_acgt(in_q.base) &&
            !(in_q.quality_present && (qual_cut_q != 8'd0) && (in_q.quality <= qual_cut_q));
    len_p   = p - seg_start_q;
    p_plus1 = {1'b0, p} + (PW+1)'(1);
    p_plus2 = {1'b0, p} + (PW+1)'(2);
    ns_wide = (p_plus2 > (PW+1)'(h_eff)) ? p_plus2 - (PW+1)'(h_eff) : '0;
    // a restart never moves the start backward
    ns      = (ns_wide[PW-1:0] < seg_start_q) ? seg_start_q : ns_wide[PW-1:0];
    run_new = (in_q.base == prev_base_q) ?
              ((run_len_q < kcs_pkg::RUN_MAX) ? run_len_q + 8'd1 : run_len_q) : 8'd1;

    emit0       = 1'b0;
    open_mid    = seg_open_q;
    start_mid   = seg_start_q;
    run_len_d   = run_len_q;
    prev_base_d = prev_base_q;

    if (!good) begin
      emit0       = seg_open_q && (len_p >= PW'(k_eff));
      open_mid    = 1'b0;
      start_mid   = '0;
      run_len_d   = '0;
      prev_base_d = '0;
    end else if (!seg_open_q) begin
      open_mid    = 1'b1;
      start_mid   = p;
      run_len_d   = 8'd1;
      prev_base_d = in_q.base;
    end else begin
      prev_base_d = in_q.base;
      run_len_d   = run_new;
      if ((h_eff != 8'd0) && (run_new >= h_eff)) begin
        emit0     = (len_p >= PW'(k_eff));
        start_mid = ns;
        run_len_d = h_eff - 8'd1;
      end
    end

    e_last    = (p < kcs_pkg::MAX_READ_LEN) ? p_plus1[PW-1:0] : kcs_pkg::MAX_READ_LEN;
    emit_last = in_q.last_base && open_mid && ((e_last - start_mid) >= PW'(k_eff));

    seg_open_d  = open_mid;
    seg_start_d = start_mid;
    if (in_q.last_base) begin
      base_index_d = '0;
      seg_open_d   = 1'b0;
      seg_start_d  = '0;
      run_len_d    = '0;
      prev_base_d  = '0;
    end else begin
      base_index_d = e_last;
    end
  end

  always_comb begin
    res_first.contig_begin = seg_start_q;
    res_first.contig_stop  = p;
    res_first.last_of_run  = !emit_last;
    res_last.contig_begin  = start_mid;
    res_last.contig_stop   = e_last;
    res_last.last_of_run   = 1'b1;

    push.push0 = proc && (emit0 || emit_last);
    push.push1 = proc && emit0 && emit_last;
    push.item0 = emit0 ? res_first : res_last;
    push.item1 = res_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_index_q <= '0;
      seg_start_q  <= '0;
      seg_open_q   <= 1'b0;
      run_len_q    <= '0;
      prev_base_q  <= '0;
    end else if (proc) begin
      base_index_q <= base_index_d;
      seg_start_q  <= seg_start_d;
      seg_open_q   <= seg_open_d;
      run_len_q    <= run_len_d;
      prev_base_q  <= prev_base_d;
    end
  end

  kcs_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== design/kcs_checker.sv =====
// Port-level checks for the k-mer contig segmenter, bound to the top level.
module kcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input kcs_pkg::out_item_t            out_item_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // The second result of a base is queued together with the first.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last_of_run |=> out_valid_o)
    else $error("second result of a base missing");

  // Every reported contig is non-empty.
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.contig_stop > out_item_o.contig_begin)
    else $error("contig stop not past its begin");

  // Input never stalls while the result side is idle and drained.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result queue");

endmodule

bind kmer_contig_segmenter kcs_checker u_kcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the k-mer contig segmenter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall_o;
  kcs_pkg::in_item_t in_item = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  kcs_pkg::out_item_t out_item_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [kcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  kmer_contig_segmenter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stimulus and scoreboard state
  kcs_pkg::in_item_t base_q[$];
  kcs_pkg::out_item_t contig_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Mirror of the block's registers and contig tracking state
  logic [7:0] kmer_len = kcs_pkg::KMER_SIZE_RST;
  logic [7:0] qual_cut = kcs_pkg::QUAL_CUT_RST;
  logic [7:0] homo_len = kcs_pkg::HOMO_CUT_RST;
  logic [kcs_pkg::POS_W-1:0] base_pos = '0;
  logic [kcs_pkg::POS_W-1:0] seg_start = '0;
  logic seg_open = 1'b0;
  logic [7:0] run_len = '0;
  logic [7:0] prev_base = '0;

  function automatic logic is_nucleotide(logic [7:0] c);
    case (c)
      "A", "C", "G", "T", "a", "c", "g", "t": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_nuc(int unsigned i);
    case (i % 4)
      0: return "A";
      1: return "C";
      2: return "G";
      default: return "T";
    endcase
  endfunction

  function automatic kcs_pkg::out_item_t make_contig(int unsigned b, int unsigned e);
    kcs_pkg::out_item_t r;
    r.contig_begin = b[kcs_pkg::POS_W-1:0];
    r.contig_stop = e[kcs_pkg::POS_W-1:0];
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Advance the contig tracker by one base and queue the contigs it closes.
  function automatic void predict_contigs(kcs_pkg::in_item_t it);
    int unsigned p, k, h, e, ns, st;
    logic good;
    kcs_pkg::out_item_t found[$];
    p = base_pos;
    st = seg_start;
    k = (kmer_len == 0) ? 1 : kmer_len;
    h = (homo_len == 1) ? 2 : homo_len;
    good = is_nucleotide(it.base);
    if (it.quality_present && qual_cut != 0 && it.quality <= qual_cut) good = 1'b0;
    if (!good) begin
      if (seg_open && p - st >= k) found.push_back(make_contig(st, p));
      seg_open = 1'b0;
      st = 0;
      run_len = '0;
      prev_base = '0;
    end else if (!seg_open) begin
      seg_open = 1'b1;
      st = p;
      run_len = 8'd1;
      prev_base = it.base;
    end else begin
      if (it.base == prev_base) begin
        if (run_len < kcs_pkg::RUN_MAX) run_len = run_len + 8'd1;
      end else begin
        run_len = 8'd1;
      end
      prev_base = it.base;
      if (h != 0 && run_len >= h) begin
        if (p - st >= k) found.push_back(make_contig(st, p));
        ns = (p + 2 > h) ? p + 2 - h : 0;
        if (ns < st) ns = st;
        st = ns;
        run_len = 8'(h - 1);
      end
    end
    if (it.last_base) begin
      e = (p < kcs_pkg::MAX_READ_LEN) ? p + 1 : kcs_pkg::MAX_READ_LEN;
      if (seg_open && e >= st && e - st >= k) found.push_back(make_contig(st, e));
      p = 0;
      seg_open = 1'b0;
      st = 0;
      run_len = '0;
      prev_base = '0;
    end else begin
      p = (p < kcs_pkg::MAX_READ_LEN) ? p + 1 : kcs_pkg::MAX_READ_LEN;
    end
    base_pos = p[kcs_pkg::POS_W-1:0];
    seg_start = st[kcs_pkg::POS_W-1:0];
    if (found.size() > 2) found = found[0:1];
    if (found.size() > 0) found[found.size()-1].last_of_run = 1'b1;
    foreach (found[i]) contig_q.push_back(found[i]);
  endfunction

  // Driver: predict on acceptance, then present the next base or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && !in_stall_o) predict_contigs(in_item);
      if (!in_valid || !in_stall_o) begin
        if (base_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= base_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each accepted contig
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (contig_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected contig begin=%0d stop=%0d last=%0b",
                     out_item_o.contig_begin, out_item_o.contig_stop,
                     out_item_o.last_of_run);
          mismatches++;
        end else begin
          kcs_pkg::out_item_t want;
          want = contig_q.pop_front();
          if (out_item_o.contig_begin !== want.contig_begin ||
              out_item_o.contig_stop !== want.contig_stop ||
              out_item_o.last_of_run !== want.last_of_run) begin
            if (mismatches < MAX_REPORTS)
              $display("contig mismatch: exp %0d..%0d last=%0b, got %0d..%0d last=%0b",
                       want.contig_begin, want.contig_stop, want.last_of_run,
                       out_item_o.contig_begin, out_item_o.contig_stop,
                       out_item_o.last_of_run);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[kmer_contig_segmenter] ERROR");
      $finish;
    end
  end

  task automatic push_base(logic [7:0] b, logic [7:0] q, logic qp, logic last);
    kcs_pkg::in_item_t it;
    it.base = b;
    it.quality = q;
    it.quality_present = qp;
    it.last_base = last;
    base_q.push_back(it);
  endtask

  // Hold until every base is in and every contig is out, then let the pipe empty.
  task automatic drain();
    while (base_q.size() != 0 || in_valid || contig_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(kcs_pkg::cfg_reg_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      kcs_pkg::CFG_KMER_SIZE: kmer_len = val;
      kcs_pkg::CFG_QUAL_CUT:  qual_cut = val;
      kcs_pkg::CFG_HOMO_CUT:  homo_len = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [7:0] k, logic [7:0] q, logic [7:0] h);
    write_reg(kcs_pkg::CFG_KMER_SIZE, k);
    write_reg(kcs_pkg::CFG_QUAL_CUT, q);
    write_reg(kcs_pkg::CFG_HOMO_CUT, h);
  endtask

  // Mostly valid bases with runs, some N and random bytes as breaks.
  task automatic queue_random_reads(int unsigned n_items, int unsigned max_len);
    int unsigned left, len, sel;
    logic [7:0] b, q, prev;
    logic qp;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(max_len, 1);
      if (len > left) len = left;
      prev = "A";
      for (int unsigned i = 0; i < len; i++) begin
        sel = $urandom_range(99);
        if (sel < 30) begin
          b = prev;
        end else if (sel < 88) begin
          b = pick_nuc($urandom_range(3));
          if ($urandom_range(3) == 0) b = b | 8'h20;
        end else if (sel < 95) begin
          b = ($urandom_range(1) != 0) ? "N" : "n";
        end else begin
          b = 8'($urandom_range(255));
        end
        qp = ($urandom_range(9) != 0);
        if ($urandom_range(99) < 75 && qual_cut != 8'hFF)
          q = 8'($urandom_range(255, qual_cut + 1));
        else
          q = 8'($urandom_range(255));
        push_base(b, q, qp, i == len - 1);
        prev = b;
      end
      left -= len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 8;
    recv_idle_pct = 84;

    // Directed read: equal quality fails, missing quality passes, case matters,
    // run break restarts inside the run, extreme bytes
    set_regs(8'd2, 8'd30, 8'd3);
    push_base("A", 8'd31, 1'b1, 1'b0);
    push_base("C", 8'd31, 1'b1, 1'b0);
    push_base("G", 8'd30, 1'b1, 1'b0);
    push_base("G", 8'd0, 1'b0, 1'b0);
    push_base("t", 8'hFF, 1'b1, 1'b0);
    push_base("T", 8'hFF, 1'b1, 1'b0);
    push_base("T", 8'hFF, 1'b1, 1'b0);
    push_base("T", 8'hFF, 1'b1, 1'b0);
    push_base("a", 8'd40, 1'b1, 1'b0);
    push_base(8'hFF, 8'd40, 1'b1, 1'b0);
    push_base(8'h00, 8'd0, 1'b1, 1'b0);
    push_base("c", 8'hFF, 1'b1, 1'b1);
    // Short read closed by its last base
    push_base("A", 8'd50, 1'b1, 1'b0);
    push_base("C", 8'd50, 1'b1, 1'b1);
    // Last base also breaks a run: two contigs from one base
    push_base("C", 8'd50, 1'b1, 1'b0);
    push_base("G", 8'd50, 1'b1, 1'b0);
    push_base("G", 8'd50, 1'b0, 1'b0);
    push_base("G", 8'd50, 1'b1, 1'b1);
    // Single-base read that fails
    push_base("N", 8'd0, 1'b0, 1'b1);
    drain();

    set_regs(8'd3, 8'd0, 8'd0);
    queue_random_reads(30, 12);
    drain();
    set_regs(8'd5, 8'd40, 8'd3);
    queue_random_reads(30, 16);
    drain();

    send_idle_pct = 84;
    recv_idle_pct = 8;
    set_regs(8'd1, 8'd255, 8'd1);
    queue_random_reads(20, 10);
    drain();
    set_regs(8'd0, 8'd20, 8'd2);
    queue_random_reads(20, 10);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Widest contig and longest run cutoff: a run long enough to saturate
    set_regs(8'd255, 8'd0, 8'd255);
    for (int unsigned i = 0; i < 270; i++)
      push_base((i >= 5 && i < 265) ? "A" : pick_nuc(i), 8'd0, 1'b0, i == 269);
    drain();
    set_regs(8'd7, 8'd33, 8'd4);
    queue_random_reads(20, 20);
    drain();

    repeat (20) @(posedge clk_i);
    if (contig_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("[kmer_contig_segmenter] OK");
    end else begin
      $display("[kmer_contig_segmenter] ERROR");
    end
    $finish;
  end

endmodule
